/* rtl/text_terminal_cell_buffer_top_assert.svh */
// Assertion macros for the checker file of the terminal cell buffer.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef TEXT_TERMINAL_CELL_BUFFER_TOP_ASSERT_SVH
`define TEXT_TERMINAL_CELL_BUFFER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TTCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TTCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ttcb_pkg.sv */
package ttcb_pkg;

	// Function codes of an input item.
	localparam logic [2:0] FN_PUT  = 3'd0;
	localparam logic [2:0] FN_VUP  = 3'd1;
	localparam logic [2:0] FN_VDN  = 3'd2;
	localparam logic [2:0] FN_READ = 3'd3;
	localparam logic [2:0] FN_CLR  = 3'd4;

	// Control characters.
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_SPACE = 8'd32;

	// Colors used after reset.
	localparam logic [23:0] RESET_FG = 24'hCCDDFF;
	localparam logic [23:0] RESET_BG = 24'h050508;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEFAULT_FG   = 2'd0;
	localparam logic [1:0] REG_DEFAULT_BG   = 2'd1;
	localparam logic [1:0] REG_VISIBLE_ROWS = 2'd2;

	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  char_code;
		logic [23:0] char_fg;
		logic [23:0] char_bg;
		logic [5:0]  read_row;
		logic [6:0]  read_col;
	} item_t;

	typedef struct packed {
		logic [5:0]  cursor_row;
		logic [7:0]  cursor_col;
		logic [5:0]  view_top;
		logic [7:0]  cell_char;
		logic [23:0] cell_fg;
		logic [23:0] cell_bg;
	} result_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic [23:0] fg;
		logic [23:0] bg;
	} cell_t;

	// Decoded operation of the item in progress.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_NL,
		OP_CR,
		OP_BS,
		OP_PRINT,
		OP_WRAP,
		OP_VUP,
		OP_VDN,
		OP_READ,
		OP_CLR
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_LCLR,
		ST_PUT,
		ST_RDWAIT,
		ST_ACLR,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic put;
		logic line_sweep;
		logic all_sweep;
		logic init_fill;
		logic rd_take;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic line_last;
		logic all_last;
	} sts_t;

endpackage

/* rtl/ttcb_ram.sv */
module ttcb_ram #(
	parameter int WIDTH = 56,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/ttcb_ctrl.sv */
module ttcb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ttcb_pkg::sts_t sts,
	output ttcb_pkg::ctl_t ctl,
	output logic          busy,
	output logic          done
);

	import ttcb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.all_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.op)
					OP_NL, OP_WRAP: state_d = ST_LCLR;
					OP_READ:        state_d = ST_RDWAIT;
					OP_CLR:         state_d = ST_ACLR;
					default:        state_d = ST_RESP;
				endcase
			end
			ST_LCLR: begin
				if (sts.line_last) state_d = (sts.op == OP_WRAP) ? ST_PUT : ST_RESP;
			end
			ST_PUT:    state_d = ST_RESP;
			ST_RDWAIT: state_d = ST_RESP;
			ST_ACLR: begin
				if (sts.all_last) state_d = ST_RESP;
			end
			ST_RESP:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_INIT: begin
				ctl.all_sweep = 1'b1;
				ctl.init_fill = 1'b1;
			end
			ST_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				ctl.put  = (sts.op == OP_PRINT);
			end
			ST_LCLR:   ctl.line_sweep = 1'b1;
			ST_PUT:    ctl.put        = 1'b1;
			ST_RDWAIT: ctl.rd_take    = 1'b1;
			ST_ACLR:   ctl.all_sweep  = 1'b1;
			ST_RESP:   done           = 1'b1;
			default:   ;
		endcase
	end

endmodule

/* rtl/ttcb_datapath.sv */
module ttcb_datapath #(
	parameter int LINES = 64,
	parameter int COLS  = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ttcb_pkg::ctl_t    ctl,
	output ttcb_pkg::sts_t    sts,
	input  ttcb_pkg::item_t   item,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output ttcb_pkg::result_t result
);

	import ttcb_pkg::*;

	localparam int RW    = $clog2(LINES);
	localparam int CW    = $clog2(COLS);
	localparam int CW1   = $clog2(COLS + 1);
	localparam int DEPTH = LINES * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CELLW = $bits(cell_t);

	localparam logic [RW-1:0] LAST_ROW  = RW'(LINES - 1);
	localparam logic [RW:0]   LINES_W   = (RW + 1)'(LINES);
	localparam logic [CW1-1:0] COLS_W   = CW1'(COLS);
	localparam logic [AW-1:0] COLS_A    = AW'(COLS);
	localparam logic [AW-1:0] LINE_END  = AW'(COLS - 1);
	localparam logic [AW-1:0] STORE_END = AW'(DEPTH - 1);
	localparam logic [8:0]    BOUND_MAX = 9'(LINES - 1);

	item_t          item_q;
	op_t            op_q;
	op_t            op_d;
	cell_t          cell_q;
	logic [RW-1:0]  row_q;
	logic [CW1-1:0] col_q;
	logic [RW-1:0]  view_q;
	logic [RW-1:0]  base_q;
	logic [AW-1:0]  swp_q;
	logic [23:0]    dfg_q;
	logic [23:0]    dbg_q;
	logic [6:0]     vis_q;

	logic          at_bottom;
	logic [RW-1:0] nl_row;
	logic [RW-1:0] nl_base;
	logic [RW-1:0] nl_view_dec;
	logic [RW-1:0] nl_bound;
	logic [RW-1:0] cur_bound;
	logic          read_ok;
	logic          rd_sel;
	logic [RW-1:0] addr_row;
	logic [RW-1:0] phys_row;
	logic [AW-1:0] row_base;
	logic [CW-1:0] addr_col;
	logic [AW-1:0] addr;
	logic          we;
	cell_t         wdata;
	logic [CELLW-1:0] rdata;

	// Lowest view line that keeps the given row on screen, saturated to the last line.
	function automatic logic [RW-1:0] bound_f(input logic [RW-1:0] row,
	                                          input logic [6:0] vis);
		logic [8:0] r1;
		logic [8:0] d;
		r1 = 9'(row) + 9'd1;
		d  = r1 - 9'(vis);
		if (r1 <= 9'(vis)) begin
			d = '0;
		end else if (d > BOUND_MAX) begin
			d = BOUND_MAX;
		end
		return RW'(d);
	endfunction

	// Logical line to physical line of the ring.
	function automatic logic [RW-1:0] phys_f(input logic [RW-1:0] row,
	                                         input logic [RW-1:0] base);
		logic [RW:0] s;
		s = {1'b0, row} + {1'b0, base};
		if (s >= LINES_W) begin
			s = s - LINES_W;
		end
		return RW'(s);
	endfunction

	assign read_ok = ({3'b000, item.read_row} < 9'(LINES)) &&
	                 ({2'b00, item.read_col} < 9'(COLS));

	always_comb begin
		op_d = OP_NOP;
		case (item.func)
			FN_PUT: begin
				case (item.char_code)
					CH_NL:   op_d = OP_NL;
					CH_CR:   op_d = OP_CR;
					CH_BS:   op_d = OP_BS;
					default: op_d = (col_q >= COLS_W) ? OP_WRAP : OP_PRINT;
				endcase
			end
			FN_VUP:  op_d = OP_VUP;
			FN_VDN:  op_d = OP_VDN;
			FN_READ: op_d = read_ok ? OP_READ : OP_NOP;
			FN_CLR:  op_d = OP_CLR;
			default: op_d = OP_NOP;
		endcase
	end

	assign at_bottom   = (row_q == LAST_ROW);
	assign nl_row      = at_bottom ? row_q : row_q + 1'b1;
	assign nl_base     = !at_bottom ? base_q : ((base_q == LAST_ROW) ? '0 : base_q + 1'b1);
	assign nl_view_dec = (at_bottom && (view_q != '0)) ? view_q - 1'b1 : view_q;
	assign nl_bound    = bound_f(nl_row, vis_q);
	assign cur_bound   = bound_f(row_q, vis_q);

	// Store address: ring line times the row pitch plus the column.
	assign rd_sel   = ctl.exec && (op_q == OP_READ);
	assign addr_row = rd_sel ? RW'(item_q.read_row) : row_q;
	assign phys_row = phys_f(addr_row, base_q);
	assign row_base = AW'(phys_row) * COLS_A;

	always_comb begin
		if (ctl.line_sweep) begin
			addr_col = CW'(swp_q);
		end else if (rd_sel) begin
			addr_col = CW'(item_q.read_col);
		end else if (ctl.exec && (op_q == OP_BS)) begin
			addr_col = CW'(col_q - 1'b1);
		end else begin
			addr_col = CW'(col_q);
		end
	end

	assign addr = ctl.all_sweep ? swp_q : row_base + AW'(addr_col);

	assign we = ctl.line_sweep || ctl.all_sweep || ctl.put ||
	            (ctl.exec && (op_q == OP_BS) && (col_q != '0));

	always_comb begin
		if (ctl.put) begin
			wdata = '{ch: item_q.char_code, fg: item_q.char_fg, bg: item_q.char_bg};
		end else if (ctl.init_fill) begin
			wdata = '{ch: CH_SPACE, fg: RESET_FG, bg: RESET_BG};
		end else begin
			wdata = '{ch: CH_SPACE, fg: dfg_q, bg: dbg_q};
		end
	end

	ttcb_ram #(
		.WIDTH (CELLW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			item_q <= item;
		end
		if (ctl.exec) begin
			cell_q <= '0;
		end else if (ctl.rd_take) begin
			cell_q <= cell_t'(rdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= OP_NOP;
			row_q  <= '0;
			col_q  <= '0;
			view_q <= '0;
			base_q <= '0;
			swp_q  <= '0;
			dfg_q  <= RESET_FG;
			dbg_q  <= RESET_BG;
			vis_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_DEFAULT_FG:   dfg_q <= cfg_data;
					REG_DEFAULT_BG:   dbg_q <= cfg_data;
					REG_VISIBLE_ROWS: vis_q <= cfg_data[6:0];
					default:          ;
				endcase
			end
			if (ctl.capture) begin
				op_q <= op_d;
			end
			if (ctl.exec) begin
				swp_q <= '0;
			end else if (ctl.line_sweep || ctl.all_sweep) begin
				swp_q <= swp_q + 1'b1;
			end
			if (ctl.exec) begin
				case (op_q)
					OP_NL, OP_WRAP: begin
						row_q  <= nl_row;
						base_q <= nl_base;
						view_q <= (nl_view_dec < nl_bound) ? nl_bound : nl_view_dec;
						col_q  <= '0;
					end
					OP_CR: col_q <= '0;
					OP_BS: begin
						if (col_q != '0) col_q <= col_q - 1'b1;
					end
					OP_VUP: begin
						if (view_q != '0) view_q <= view_q - 1'b1;
					end
					OP_VDN: begin
						if (view_q < cur_bound) view_q <= view_q + 1'b1;
					end
					OP_CLR: begin
						row_q  <= '0;
						col_q  <= '0;
						view_q <= '0;
						base_q <= '0;
					end
					default: ;
				endcase
			end
			if (ctl.put) begin
				col_q <= col_q + 1'b1;
				if (view_q < cur_bound) view_q <= cur_bound;
			end
		end
	end

	assign sts.op        = op_q;
	assign sts.line_last = (swp_q == LINE_END);
	assign sts.all_last  = (swp_q == STORE_END);

	assign result.cursor_row = 6'(row_q);
	assign result.cursor_col = 8'(col_q);
	assign result.view_top   = 6'(view_q);
	assign result.cell_char  = cell_q.ch;
	assign result.cell_fg    = cell_q.fg;
	assign result.cell_bg    = cell_q.bg;

endmodule

/* rtl/text_terminal_cell_buffer_top.sv */
// Sequence: for return, view moves, backspace, printable characters and no-ops, an accepted
// item passes an execute state and then a response state with the result strobe; a cell read
// adds a read-wait state, a newline a line sweep, a wrapping printable character a line sweep
// and a put state, and a clear-all a sweep of the whole store. The next item is taken in the
// idle state after the strobe; the single write port of the cell RAM, one cell a cycle, sets
// the length of every clearing sweep. Reset: cursor, view and registers return at once; the
// cell RAM is then filled with spaces in the reset colors, with busy high; results cannot stall.
module text_terminal_cell_buffer_top #(
	parameter int LINES = 64,
	parameter int COLS  = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ttcb_pkg::item_t   item,
	output logic              done,
	output ttcb_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data
);

	import ttcb_pkg::*;

	// The controller sequences each item through the datapath: it captures the item,
	// runs the execute state, and then, depending on the decoded operation, sweeps a
	// line or the whole store, writes a wrapped character, or waits for read data.
	ctl_t ctl;
	sts_t sts;

	ttcb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the cursor, the view, the ring base of the line store, the
	// configuration registers and the cell RAM. Scrolling moves the ring base instead
	// of copying lines, so only the new bottom line has to be cleared.
	ttcb_datapath #(
		.LINES (LINES),
		.COLS  (COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.item      (item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

/* rtl/ttcb_checker.sv */
`include "text_terminal_cell_buffer_top_assert.svh"

module ttcb_checker #(
	parameter int COLS = 128
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input ttcb_pkg::result_t result
);

	import ttcb_pkg::*;

	// A result is only shown while an item is in progress.
	`TTCB_ASSERT_IMP(a_done_busy, done, busy, "result strobe outside an item")

	// An accepted item blocks the next one.
	`TTCB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

	// The strobe lasts one cycle and ends the item.
	`TTCB_ASSERT_NXT(a_done_ends, done, !busy && !done, "item did not end after its result")

	// The cursor column never goes past the line end.
	`TTCB_ASSERT_IMP(a_col_range, done, (COLS > 255) || (result.cursor_col <= 8'(COLS)),
		"cursor column beyond the line end")

endmodule

bind text_terminal_cell_buffer_top ttcb_checker #(.COLS(COLS)) u_ttcb_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import ttcb_pkg::*;

	localparam int LINES = 64;
	localparam int COLS  = 128;

	// Function codes that the block decodes as no-ops.
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	// Longest sender gap that the gap picker can return.
	localparam int MAX_GAP = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = REG_DEFAULT_FG;
	logic [23:0] cfg_data = '0;

	text_terminal_cell_buffer_top #(
		.LINES(LINES),
		.COLS (COLS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Items waiting to be sent, and the results that the terminal predictor has
	// worked out for items the block already took, oldest first.
	item_t   pending[$];
	result_t expected[$];

	int      fail_cnt = 0;
	int      gap_left = 0;
	bit      no_gaps = 1'b0;
	longint  cycle_cnt = 0;
	// Worst-case cycle count of everything queued so far; the watchdog limit
	// is several times this figure. The reset fill of the cell RAM is included.
	longint  cycle_budget = LINES * COLS + 1000;

	// ------------------------------------------------------------------
	// Terminal predictor: its own copy of the screen, cursor, view and the
	// three registers. It is stepped once for every item the block takes.
	// ------------------------------------------------------------------
	cell_t       screen [LINES][COLS];
	int          cur_row;
	int          cur_col;
	int          view_line;
	logic [23:0] dflt_fg;
	logic [23:0] dflt_bg;
	logic [6:0]  vis_rows;

	function automatic void blank_row(int r);
		for (int c = 0; c < COLS; c++) begin
			screen[r][c] = '{ch: CH_SPACE, fg: dflt_fg, bg: dflt_bg};
		end
	endfunction

	function automatic void clear_screen();
		for (int r = 0; r < LINES; r++) begin
			blank_row(r);
		end
		cur_row = 0;
		cur_col = 0;
		view_line = 0;
	endfunction

	// Lowest view line that keeps the cursor row in the window. With an empty
	// window the bound would pass the last line, so it saturates there.
	function automatic int view_floor();
		int b;
		if (cur_row + 1 <= int'(vis_rows)) return 0;
		b = cur_row + 1 - int'(vis_rows);
		return (b > LINES - 1) ? LINES - 1 : b;
	endfunction

	function automatic void follow_cursor();
		int b;
		b = view_floor();
		if (view_line < b) view_line = b;
	endfunction

	function automatic void line_feed();
		cur_row++;
		if (cur_row >= LINES) begin
			// Bottom line reached: the whole screen moves up by one line.
			for (int r = 0; r < LINES - 1; r++) begin
				for (int c = 0; c < COLS; c++) begin
					screen[r][c] = screen[r + 1][c];
				end
			end
			cur_row = LINES - 1;
			if (view_line > 0) view_line--;
		end
		blank_row(cur_row);
		cur_col = 0;
		follow_cursor();
	endfunction

	function automatic void put_char(logic [7:0] ch, logic [23:0] fg, logic [23:0] bg);
		if (ch == CH_NL) begin
			line_feed();
		end else if (ch == CH_CR) begin
			cur_col = 0;
		end else if (ch == CH_BS) begin
			if (cur_col > 0) begin
				cur_col--;
				screen[cur_row][cur_col] = '{ch: CH_SPACE, fg: dflt_fg, bg: dflt_bg};
			end
		end else begin
			// A full line wraps before the character goes in.
			if (cur_col >= COLS) line_feed();
			screen[cur_row][cur_col] = '{ch: ch, fg: fg, bg: bg};
			cur_col++;
			follow_cursor();
		end
	endfunction

	function automatic result_t term_step(item_t it);
		result_t res;
		res = '0;
		case (it.func)
			FN_PUT: put_char(it.char_code, it.char_fg, it.char_bg);
			FN_VUP: begin
				if (view_line > 0) view_line--;
			end
			FN_VDN: begin
				if (view_line < view_floor()) view_line++;
			end
			FN_READ: begin
				if (int'(it.read_row) < LINES && int'(it.read_col) < COLS) begin
					res.cell_char = screen[it.read_row][it.read_col].ch;
					res.cell_fg   = screen[it.read_row][it.read_col].fg;
					res.cell_bg   = screen[it.read_row][it.read_col].bg;
				end
			end
			FN_CLR: clear_screen();
			default: ;
		endcase
		res.cursor_row = cur_row[5:0];
		res.cursor_col = cur_col[7:0];
		res.view_top   = view_line[5:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Item generation.
	// ------------------------------------------------------------------

	// Every field but the function code gets random content; the caller overrides what matters.
	function automatic item_t rand_item(logic [2:0] fn);
		item_t it;
		it.func      = fn;
		it.char_code = 8'($urandom);
		it.char_fg   = 24'($urandom);
		it.char_bg   = 24'($urandom);
		it.read_row  = 6'($urandom);
		it.read_col  = 7'($urandom);
		return it;
	endfunction

	function automatic item_t char_item(logic [7:0] ch);
		item_t it;
		it = rand_item(FN_PUT);
		it.char_code = ch;
		return it;
	endfunction

	function automatic item_t printable_item();
		logic [7:0] ch;
		do ch = 8'($urandom); while (ch == CH_NL || ch == CH_CR || ch == CH_BS);
		return char_item(ch);
	endfunction

	// Reads lean toward the top and bottom lines and the left columns, where
	// text actually lands; the rest cover the whole screen.
	function automatic item_t read_item();
		item_t it;
		int    r;
		it = rand_item(FN_READ);
		r = $urandom_range(0, 99);
		if (r < 30) it.read_row = 6'($urandom_range(LINES - 8, LINES - 1));
		else if (r < 60) it.read_row = 6'($urandom_range(0, 7));
		if ($urandom_range(0, 1)) it.read_col = 7'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic item_t cell_read(int r, int c);
		item_t it;
		it = rand_item(FN_READ);
		it.read_row = 6'(r);
		it.read_col = 7'(c);
		return it;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 4);
		if (r < 97) return $urandom_range(5, 20);
		return $urandom_range(40, MAX_GAP);
	endfunction

	task automatic queue_item(item_t it);
		pending.push_back(it);
		cycle_budget += (it.func == FN_CLR) ? LINES * COLS + 4 : COLS + 4;
		cycle_budget += MAX_GAP + 2;
	endtask

	// Directed opening: reset contents, extreme characters and colors, every
	// control character including a backspace at column zero, both view moves,
	// the unused function codes and a clear-all.
	task automatic queue_directed();
		item_t it;
		queue_item(cell_read(0, 0));
		queue_item(cell_read(LINES - 1, COLS - 1));
		it = char_item(8'h41);
		it.char_fg = 24'h000000;
		it.char_bg = 24'hFFFFFF;
		queue_item(it);
		it = char_item(8'hFF);
		it.char_fg = 24'hFFFFFF;
		it.char_bg = 24'h000000;
		queue_item(it);
		queue_item(char_item(8'h00));
		queue_item(cell_read(0, 1));
		queue_item(char_item(CH_BS));
		queue_item(cell_read(0, 2));
		queue_item(char_item(CH_CR));
		queue_item(char_item(CH_BS));
		queue_item(char_item(CH_NL));
		queue_item(rand_item(FN_VUP));
		queue_item(rand_item(FN_VDN));
		queue_item(rand_item(FN_VDN));
		for (logic [3:0] f = FN_SPARE_LO; f <= FN_SPARE_HI; f++) begin
			queue_item(rand_item(f[2:0]));
		end
		queue_item(cell_read(1, 0));
		queue_item(char_item(8'h7A));
		queue_item(rand_item(FN_CLR));
		queue_item(cell_read(0, 0));
		queue_item(cell_read(1, 0));
	endtask

	// A random phase looks like terminal traffic: mixed text with control
	// characters, full lines that wrap, runs of newlines that push the cursor to
	// the bottom and scroll, and a little noise with every field random.
	task automatic queue_text_phase(int n_items);
		int    made;
		int    seg;
		int    len;
		item_t it;
		made = 0;
		if ($urandom_range(0, 1)) begin
			queue_item(rand_item(FN_CLR));
			made++;
		end
		while (made < n_items) begin
			seg = $urandom_range(0, 99);
			if (seg < 8) begin
				len = $urandom_range(COLS, COLS + 12);
				repeat (len) queue_item(printable_item());
				made += len;
			end else if (seg < 13) begin
				len = $urandom_range(4, 16);
				repeat (len) queue_item(char_item(CH_NL));
				made += len;
			end else if (seg < 16) begin
				repeat (6) begin
					it = rand_item(3'($urandom));
					if (it.func == FN_CLR) it.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
					queue_item(it);
					if (it.func < FN_SPARE_LO) made++;
				end
			end else begin
				seg = $urandom_range(0, 99);
				if (seg < 55) queue_item(printable_item());
				else if (seg < 67) queue_item(char_item(CH_NL));
				else if (seg < 71) queue_item(char_item(CH_CR));
				else if (seg < 77) queue_item(char_item(CH_BS));
				else if (seg < 87) queue_item(read_item());
				else if (seg < 93) queue_item(rand_item(FN_VUP));
				else if (seg < 99) queue_item(rand_item(FN_VDN));
				else queue_item(rand_item(FN_PUT));
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Configuration writes happen only while the block is idle, so the
	// predictor's copy of the registers can change at the same edge.
	// ------------------------------------------------------------------
	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_DEFAULT_FG:   dflt_fg = val;
			REG_DEFAULT_BG:   dflt_bg = val;
			REG_VISIBLE_ROWS: vis_rows = val[6:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Waits at falling edges, after the driver and the checker have settled,
	// until nothing is queued, in flight or owed. Then a short pause lets the
	// block return to idle after its strobe.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending.size() != 0 || start || busy || expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the next pending item after a random gap. An item is
	// taken at an edge where start is high and busy is low; the predictor is
	// stepped right there. With a zero gap start simply stays high.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_proc
		logic  go;
		item_t next_item;
		if (arst_n) begin
			go = start;
			next_item = item;
			if (start && !busy) begin
				expected.push_back(term_step(item));
				go = 1'b0;
				gap_left = no_gaps ? 0 : pick_gap();
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0) begin
					next_item = pending.pop_front();
					go = 1'b1;
				end
			end
			start <= go;
			item  <= next_item;
		end
	end

	// ------------------------------------------------------------------
	// Checker: a result is valid for the single cycle that done is high and
	// is compared field by field with the oldest expectation.
	// ------------------------------------------------------------------
	task automatic check_field(string what, logic [23:0] want, logic [23:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
			fail_cnt++;
		end
	endtask

	always @(posedge clk) begin : check_proc
		result_t want;
		if (arst_n && done) begin
			if (expected.size() == 0) begin
				$display("%0t: result with nothing expected, expected none actual %h",
					$time, result);
				fail_cnt++;
			end else begin
				want = expected.pop_front();
				check_field("cursor_row", 24'(want.cursor_row), 24'(result.cursor_row));
				check_field("cursor_col", 24'(want.cursor_col), 24'(result.cursor_col));
				check_field("view_top",   24'(want.view_top),   24'(result.view_top));
				check_field("cell_char",  24'(want.cell_char),  24'(result.cell_char));
				check_field("cell_fg",    want.cell_fg,         result.cell_fg);
				check_field("cell_bg",    want.cell_bg,         result.cell_bg);
			end
		end
	end

	// Watchdog: several times the worst-case length of everything queued.
	always @(posedge clk) begin : watchdog_proc
		cycle_cnt++;
		if (cycle_cnt > 4 * cycle_budget + 50000) begin
			$display("%0t: run stopped by the watchdog at cycle %0d", $time, cycle_cnt);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run: reset, the directed opening under reset settings,
	// then random phases, each under its own register settings. The settings
	// include both color extremes and window sizes from empty to full.
	// ------------------------------------------------------------------
	initial begin : sequence_proc
		int vis_plan [8];
		vis_plan = '{0, 64, 1, 63, 24, 2, 40, 8};

		dflt_fg = RESET_FG;
		dflt_bg = RESET_BG;
		vis_rows = '0;
		clear_screen();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// The block fills its cell RAM after reset with busy high.
		repeat (2) @(negedge clk);
		wait_idle();

		queue_directed();
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0) begin
				write_reg(REG_DEFAULT_FG, 24'h000000);
				write_reg(REG_DEFAULT_BG, 24'hFFFFFF);
			end else if (ph == 1) begin
				write_reg(REG_DEFAULT_FG, 24'hFFFFFF);
				write_reg(REG_DEFAULT_BG, 24'h000000);
			end else begin
				write_reg(REG_DEFAULT_FG, 24'($urandom));
				write_reg(REG_DEFAULT_BG, 24'($urandom));
			end
			write_reg(REG_VISIBLE_ROWS, 24'(vis_plan[ph]));
			// Some phases run back to back so that no gap hides timing issues.
			no_gaps = (ph % 3 == 2);
			@(negedge clk);
			queue_text_phase(244);
			// The sender holds off here until every result of the phase is in.
			wait_idle();
		end

		if (fail_cnt == 0 && expected.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
